@@ hdl/rssa_pkg.sv @@
// ----------------------------------------------------------------------------
// rssa_pkg
// shared types and constants of the rotated sorted array search block
// ----------------------------------------------------------------------------
package rssa_pkg;

  localparam int unsigned DEPTH   = 256;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = CNT_W + 1;  // signed, holds -1 .. DEPTH
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

endpackage

@@ hdl/rotated_sorted_array_search.sv @@
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// search engine over a store of words holding a rotated ascending sequence
// ----------------------------------------------------------------------------
// usage
//   s_axis carries commands: tuser = operation (0 write, 1 search),
//   tdata[7:0] = slot, tdata[39:8] = signed value. a write beat stores the
//   value at the slot and gives no output beat; a search beat gives exactly
//   one m_axis beat: tuser = found, tdata[7:0] = position (zero on a miss).
//   cfg_we_i / cfg_wdata_i set element_count, the number of loaded words
//   covered by a search (values above the store depth act as the depth);
//   write it only while no search is in flight.
// timing
//   a four-entry command queue in front of the engine takes one beat per
//   cycle until it fills. the engine retires a write without leaving idle; a
//   search walks the pivot search (rot_chk, rot_left, rot_right per step),
//   reads and checks the pivot if one is found, runs the binary search
//   (bin_chk, bin_eval per step) and loads the output register. the engine
//   takes no new command until the search is done. items stay in order.
// reset and stall
//   reset empties the queue and the output register and clears
//   element_count; store contents are undefined until written. while
//   m_axis_tready is low the finished beat holds in the output register, the
//   engine finishes its next search and waits, and the queue keeps filling.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [rssa_pkg::CNT_W-1:0]  cfg_wdata_i,
  // command stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,   // [7:0] slot, [39:8] value
  input  logic                        s_axis_tuser,   // operation
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] position
  output logic                        m_axis_tuser    // found
);

  // queue head between front and engine
  logic           cmd_valid;
  logic           cmd_pop;
  rssa_pkg::cmd_t cmd;

  // front: beat decode and command queue
  rssa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back: store, pivot and binary search, output register
  rssa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ hdl/rssa_front.sv @@
// ----------------------------------------------------------------------------
// rssa_front
// accepts input beats, classifies them and queues commands for the engine
// ----------------------------------------------------------------------------
module rssa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [39:0]         s_axis_tdata,   // [7:0] slot, [39:8] value
  input  logic                s_axis_tuser,   // operation
  output logic                cmd_valid_o,
  output rssa_pkg::cmd_t      cmd_o,
  input  logic                cmd_pop_i
);

  rssa_pkg::cmd_t                  queue_q [rssa_pkg::QDEPTH];
  logic [rssa_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rssa_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rssa_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            push, pop;
  rssa_pkg::cmd_t                  cmd_in;

  // decode the incoming beat
  always_comb begin
    cmd_in.kind  = s_axis_tuser ? rssa_pkg::KIND_SEARCH : rssa_pkg::KIND_WRITE;
    cmd_in.slot  = s_axis_tdata[rssa_pkg::SLOT_W-1:0];
    cmd_in.value = $signed(s_axis_tdata[rssa_pkg::SLOT_W +: rssa_pkg::DATA_W]);
  end

  assign s_axis_tready = (count_q != rssa_pkg::QCNT_W'(rssa_pkg::QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != '0);
  assign pop           = cmd_pop_i && cmd_valid_o;
  assign cmd_o         = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  // occupancy never goes past the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rssa_pkg::QCNT_W'(rssa_pkg::QDEPTH))
    else $error("queue count overflow");

  // pointers and count move together
  a_count_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == rssa_pkg::QCNT_W'(rssa_pkg::QDEPTH))
      || (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

  // a pop of an entry that was pushed keeps the count in step
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not drop on pop");

endmodule

@@ hdl/rssa_back.sv @@
// ----------------------------------------------------------------------------
// rssa_back
// element store, pivot search and binary search engine, result register
// ----------------------------------------------------------------------------
module rssa_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rssa_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          cmd_valid_i,
  input  rssa_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] position
  output logic                          m_axis_tuser    // found
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_CHK,
    ST_ROT_LEFT,
    ST_ROT_RIGHT,
    ST_PIV_RD,
    ST_PIV_EVAL,
    ST_BIN_CHK,
    ST_BIN_EVAL,
    ST_RESULT
  } state_e;

  typedef logic signed [rssa_pkg::IDX_W-1:0] idx_t;

  state_e                             state_q;
  logic [rssa_pkg::CNT_W-1:0]         element_count_q;
  logic signed [rssa_pkg::DATA_W-1:0] mem_q [rssa_pkg::DEPTH];
  logic signed [rssa_pkg::DATA_W-1:0] rd_a_q, rd_b_q, emid_q, target_q;
  logic [rssa_pkg::ADDR_W-1:0]        rd_addr_a, rd_addr_b;
  idx_t                               lo_q, hi_q, mid_q, piv_q;
  idx_t                               mid, n_last;
  logic signed [rssa_pkg::IDX_W:0]    sum;
  logic [rssa_pkg::CNT_W-1:0]         n_sat;
  logic                               res_found_q;
  logic [rssa_pkg::POS_W-1:0]         res_pos_q;
  logic                               out_valid_q, out_found_q;
  logic [rssa_pkg::POS_W-1:0]         out_pos_q;
  logic                               mem_we;
  logic                               out_free;

  assign n_sat  = (element_count_q > rssa_pkg::CNT_W'(rssa_pkg::DEPTH))
                  ? rssa_pkg::CNT_W'(rssa_pkg::DEPTH) : element_count_q;
  assign n_last = $signed({1'b0, n_sat}) - idx_t'(1);
  assign sum    = {lo_q[rssa_pkg::IDX_W-1], lo_q} + {hi_q[rssa_pkg::IDX_W-1], hi_q};
  assign mid    = idx_t'(sum >>> 1);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign mem_we    = cmd_pop_o && (cmd_i.kind == rssa_pkg::KIND_WRITE);
  assign out_free  = !out_valid_q || m_axis_tready;

  // read port addresses per state
  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (state_q)
      ST_ROT_CHK: begin
        rd_addr_a = mid[rssa_pkg::ADDR_W-1:0];
        rd_addr_b = rssa_pkg::ADDR_W'(mid - idx_t'(1));
      end
      ST_ROT_LEFT: begin
        rd_addr_a = rssa_pkg::ADDR_W'(mid_q + idx_t'(1));
        rd_addr_b = lo_q[rssa_pkg::ADDR_W-1:0];
      end
      ST_PIV_RD: begin
        rd_addr_a = piv_q[rssa_pkg::ADDR_W-1:0];
        rd_addr_b = '0;
      end
      ST_BIN_CHK: begin
        rd_addr_a = mid[rssa_pkg::ADDR_W-1:0];
      end
      default: begin
        rd_addr_a = '0;
        rd_addr_b = '0;
      end
    endcase
  end

  // element store, one write and two registered reads a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.slot[rssa_pkg::ADDR_W-1:0]] <= cmd_i.value;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      element_count_q <= '0;
      out_valid_q     <= 1'b0;
      out_found_q     <= 1'b0;
      out_pos_q       <= '0;
      res_found_q     <= 1'b0;
      res_pos_q       <= '0;
      lo_q            <= '0;
      hi_q            <= '0;
      mid_q           <= '0;
      piv_q           <= '0;
      emid_q          <= '0;
      target_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        element_count_q <= cfg_wdata_i;
      end
      // in ST_RESULT the output register is handled by the state itself
      if (out_valid_q && m_axis_tready && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && (cmd_i.kind == rssa_pkg::KIND_SEARCH)) begin
            target_q <= cmd_i.value;
            lo_q     <= '0;
            hi_q     <= n_last;
            state_q  <= ST_ROT_CHK;
          end
        end
        ST_ROT_CHK: begin
          if (lo_q >= hi_q) begin
            // no descent: search the whole range as unrotated
            lo_q    <= '0;
            hi_q    <= n_last;
            state_q <= ST_BIN_CHK;
          end else begin
            mid_q   <= mid;
            state_q <= ST_ROT_LEFT;
          end
        end
        ST_ROT_LEFT: begin
          if ((mid_q > lo_q) && (rd_a_q < rd_b_q)) begin
            piv_q   <= mid_q - idx_t'(1);
            state_q <= ST_PIV_RD;
          end else begin
            emid_q  <= rd_a_q;
            state_q <= ST_ROT_RIGHT;
          end
        end
        ST_ROT_RIGHT: begin
          if ((mid_q < hi_q) && (emid_q > rd_a_q)) begin
            piv_q   <= mid_q;
            state_q <= ST_PIV_RD;
          end else begin
            if (rd_b_q >= emid_q) begin
              hi_q <= mid_q - idx_t'(1);
            end else begin
              lo_q <= mid_q + idx_t'(1);
            end
            state_q <= ST_ROT_CHK;
          end
        end
        ST_PIV_RD: begin
          state_q <= ST_PIV_EVAL;
        end
        ST_PIV_EVAL: begin
          if (rd_a_q == target_q) begin
            res_found_q <= 1'b1;
            res_pos_q   <= piv_q[rssa_pkg::POS_W-1:0];
            state_q     <= ST_RESULT;
          end else if (rd_b_q <= target_q) begin
            lo_q    <= '0;
            hi_q    <= piv_q - idx_t'(1);
            state_q <= ST_BIN_CHK;
          end else begin
            lo_q    <= piv_q + idx_t'(1);
            hi_q    <= n_last;
            state_q <= ST_BIN_CHK;
          end
        end
        ST_BIN_CHK: begin
          if (lo_q > hi_q) begin
            res_found_q <= 1'b0;
            res_pos_q   <= '0;
            state_q     <= ST_RESULT;
          end else begin
            mid_q   <= mid;
            state_q <= ST_BIN_EVAL;
          end
        end
        ST_BIN_EVAL: begin
          if (rd_a_q == target_q) begin
            res_found_q <= 1'b1;
            res_pos_q   <= mid_q[rssa_pkg::POS_W-1:0];
            state_q     <= ST_RESULT;
          end else begin
            if (rd_a_q > target_q) begin
              hi_q <= mid_q - idx_t'(1);
            end else begin
              lo_q <= mid_q + idx_t'(1);
            end
            state_q <= ST_BIN_CHK;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_found_q <= res_found_q;
            out_pos_q   <= res_pos_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pos_q;
  assign m_axis_tuser  = out_found_q;

  // a miss always reports position zero
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_pos_q == '0))
    else $error("miss with nonzero position");

  // the queue is only drained while the engine is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE))
    else $error("command popped while busy");

  // a result is loaded only into a free output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_valid_q && !m_axis_tready) |=> (state_q == ST_RESULT))
    else $error("result overwrote a pending beat");

  // a search range start never goes negative
  a_lo_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIN_CHK || state_q == ST_ROT_CHK) |-> (lo_q >= idx_t'(0)))
    else $error("negative search bound");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rotated sorted array search block: loads the
// store with rotated ascending runs (plus some unsorted ones), walks the
// element count through its extremes and checks every search reply against
// a predictor that keeps its own copy of the store
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 20;  // lets queued writes drain
  localparam int unsigned TAIL_CYCLES = 60;    // longer than one full search
  localparam logic signed [rssa_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [rssa_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // one search reply as it travels on m_axis
  typedef struct packed {
    logic                        hit;
    logic [rssa_pkg::POS_W-1:0]  index;
  } search_reply_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the store and the element count, predicts each search
  // --------------------------------------------------------------------------
  class rotated_search_board;
    logic signed [rssa_pkg::DATA_W-1:0] words [rssa_pkg::DEPTH];
    int unsigned                        count_reg;
    search_reply_t                      replies_due [$];
    int unsigned                        mismatches;

    function new();
      count_reg = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void set_count(logic [rssa_pkg::CNT_W-1:0] count);
      count_reg = int'(count);
    endfunction

    // out-of-range reads give zero, but a legal run never makes one
    function logic signed [rssa_pkg::DATA_W-1:0] word_at(int idx);
      if (idx < 0 || idx >= int'(rssa_pkg::DEPTH)) return '0;
      return words[idx];
    endfunction

    // index of the last element before the descent, -1 when none is seen
    function int rotation_point(int n);
      int lo, hi, mid;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (lo >= hi) return -1;
        if (mid > lo && word_at(mid) < word_at(mid - 1)) return mid - 1;
        if (mid < hi && word_at(mid) > word_at(mid + 1)) return mid;
        if (word_at(lo) >= word_at(mid)) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    function int half_search(logic signed [rssa_pkg::DATA_W-1:0] target, int lo, int hi);
      int mid;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (word_at(mid) == target) return mid;
        if (word_at(mid) > target) hi = mid - 1;
        else lo = mid + 1;
      end
      return -1;
    endfunction

    function search_reply_t search_outcome(logic signed [rssa_pkg::DATA_W-1:0] target);
      search_reply_t reply;
      int n, pivot, match;
      n = (count_reg > rssa_pkg::DEPTH) ? int'(rssa_pkg::DEPTH) : int'(count_reg);
      pivot = rotation_point(n);
      if (pivot < 0) match = half_search(target, 0, n - 1);
      else if (word_at(pivot) == target) match = pivot;
      else if (word_at(0) <= target) match = half_search(target, 0, pivot - 1);
      else match = half_search(target, pivot + 1, n - 1);
      reply.hit = (match >= 0);
      reply.index = (match >= 0) ? match[rssa_pkg::POS_W-1:0] : '0;
      return reply;
    endfunction

    // called for every accepted command beat
    function void note_command(rssa_pkg::kind_e kind, logic [rssa_pkg::SLOT_W-1:0] slot,
                               logic signed [rssa_pkg::DATA_W-1:0] value);
      if (kind == rssa_pkg::KIND_WRITE) begin
        if (slot < rssa_pkg::DEPTH) words[slot] = value;
      end else begin
        replies_due.push_back(search_outcome(value));
      end
    endfunction

    // called for every accepted result beat
    function void check_result(logic hit, logic [rssa_pkg::POS_W-1:0] index);
      search_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with nothing pending: expected none, %s%0b %s%0d",
                 $time, "actual found=", hit, "position=", index);
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: found flag: expected %0b, actual %0b", $time, want.hit, hit);
        mismatches++;
      end
      if (index !== want.index) begin
        $display("%0t: position: expected %0d, actual %0d", $time, want.index, index);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and the block
  // --------------------------------------------------------------------------
  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [rssa_pkg::CNT_W-1:0]  cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [39:0]                 s_axis_tdata;   // [7:0] slot, [39:8] value
  logic                        s_axis_tuser;   // operation
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;   // [7:0] position
  logic                        m_axis_tuser;   // found

  rotated_search_board board;
  // what the current run put in the store
  logic signed [rssa_pkg::DATA_W-1:0] layout [rssa_pkg::DEPTH];
  bit gaps_on;      // sender may drop tvalid between beats
  bit stalls_on;    // receiver may drop tready
  int unsigned cycle_count;
  int unsigned stall_left;

  rotated_sorted_array_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies still pending", $time,
               board.replies_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check the beat taken at this edge, then choose next tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tuser, m_axis_tdata[rssa_pkg::POS_W-1:0]);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rst_ni && stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // command side
  // --------------------------------------------------------------------------

  // present one beat and hold it until the block takes it; tvalid stays high
  // afterwards so back-to-back beats need no second assignment
  task automatic send_beat(rssa_pkg::kind_e kind, logic [rssa_pkg::SLOT_W-1:0] slot,
                           logic signed [rssa_pkg::DATA_W-1:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {value, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_command(kind, slot, value);
  endtask

  task automatic send_write(logic [rssa_pkg::SLOT_W-1:0] slot,
                            logic signed [rssa_pkg::DATA_W-1:0] value);
    send_beat(rssa_pkg::KIND_WRITE, slot, value);
  endtask

  task automatic send_search(logic signed [rssa_pkg::DATA_W-1:0] target);
    // slot is don't-care
    send_beat(rssa_pkg::KIND_SEARCH, rssa_pkg::SLOT_W'($urandom_range(0, 255)), target);
  endtask

  // change element_count only with nothing in flight: all replies back, and
  // SETTLE_CYCLES more for writes still sitting in the command queue
  task automatic write_count(logic [rssa_pkg::CNT_W-1:0] count);
    s_axis_tvalid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_count(count);
  endtask

  // fill slots 0..n-1 with an ascending run rotated by a random amount;
  // now and then duplicates are allowed or the words are just random
  task automatic load_store(int n);
    longint unsigned stride_cap, total, room, offset;
    longint unsigned rise [rssa_pkg::DEPTH];
    longint level;
    logic signed [rssa_pkg::DATA_W-1:0] sorted_words [rssa_pkg::DEPTH];
    int turn, floor_step;
    bit jumbled;
    jumbled = ($urandom_range(0, 5) == 0);
    floor_step = ($urandom_range(0, 7) == 0) ? 0 : 1;
    // dense runs leave small holes for misses, wide ones spread over the range
    stride_cap = ($urandom_range(0, 1) == 0) ? 64'd3 : 64'hFFFF_FFFF / (n + 1);
    total = 0;
    for (int i = 1; i < n; i++) begin
      rise[i] = $urandom_range(floor_step, stride_cap);
      total += rise[i];
    end
    room = 64'hFFFF_FFFF - total;
    offset = {$urandom, $urandom};
    offset = offset % (room + 1);
    level = longint'(offset) - 64'sd2147483648;
    for (int i = 0; i < n; i++) begin
      if (i > 0) level += longint'(rise[i]);
      sorted_words[i] = level[31:0];
    end
    turn = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) begin
      layout[i] = jumbled ? $urandom : sorted_words[(i + turn) % n];
      send_write(8'(i), layout[i]);
    end
    // stray writes past the searched range never affect a search
    if (n < int'(rssa_pkg::DEPTH))
      repeat ($urandom_range(0, 2)) send_write(8'($urandom_range(n, 255)), $urandom);
  endtask

  // mostly loaded words, some near misses, the range ends and pure noise
  function automatic logic signed [rssa_pkg::DATA_W-1:0] pick_target(int n);
    int roll, k;
    roll = $urandom_range(0, 9);
    k = (n > 0) ? $urandom_range(0, n - 1) : 0;
    if (n > 0 && roll < 6) return layout[k];
    if (n > 0 && roll < 8) return layout[k] + (($urandom_range(0, 1) == 1) ? 1 : -1);
    if (roll == 8) return ($urandom_range(0, 1) == 1) ? WORD_MIN : WORD_MAX;
    return $urandom;
  endfunction

  task automatic run_searches(int n, int beats);
    repeat (beats) send_search(pick_target(n));
  endtask

  initial begin
    int n;
    bit quiet;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rssa_pkg::KIND_WRITE;
    m_axis_tready = 1'b1;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    cycle_count   = 0;
    stall_left    = 0;
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // empty store: every search misses
    write_count(0);
    send_search(WORD_MIN);
    send_search(WORD_MAX);
    // single element: treated as unrotated
    write_count(1);
    send_write(8'd0, 32'sd5);
    send_search(32'sd5);
    send_search(32'sd6);
    // two elements rotated by one: hit on the pivot, hit below element 0, miss
    gaps_on   <= 1'b1;
    stalls_on <= 1'b1;
    write_count(2);
    send_write(8'd0, 32'sd9);
    send_write(8'd1, -32'sd3);
    send_search(32'sd9);
    send_search(-32'sd3);
    send_search(32'sd0);
    // unrotated run spanning both range ends: no descent found; last slot
    // written with all ones to toggle every slot and value bit
    write_count(5);
    send_write(8'd0, WORD_MIN);
    send_write(8'd1, -32'sd1);
    send_write(8'd2, 32'sd0);
    send_write(8'd3, 32'sd1);
    send_write(8'd4, WORD_MAX);
    send_write(8'd255, -32'sd1);
    send_search(WORD_MIN);
    send_search(WORD_MAX);
    send_search(32'sd2);

    // ---- random part ----
    // phase 5 fills the whole store, 6 and 7 run with counts past the depth
    // (saturated), the last three phases run without any idling
    for (int phase = 0; phase < 11; phase++) begin
      quiet = (phase >= 8);
      gaps_on   <= !quiet && ($urandom_range(0, 3) != 0);
      stalls_on <= !quiet && ($urandom_range(0, 3) != 0);
      if (phase == 5) begin
        n = int'(rssa_pkg::DEPTH);
        write_count(rssa_pkg::CNT_W'(rssa_pkg::DEPTH));
        load_store(n);
        run_searches(n, 40);
      end else if (phase == 6) begin
        write_count('1);
        run_searches(n, 20);
      end else if (phase == 7) begin
        write_count(rssa_pkg::CNT_W'($urandom_range(rssa_pkg::DEPTH + 1, 510)));
        run_searches(n, 10);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
        write_count(rssa_pkg::CNT_W'(n));
        load_store(n);
        run_searches(n, $urandom_range(8, 14));
      end
    end

    // ---- drain ----
    s_axis_tvalid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rssa_pkg.sv
hdl/rssa_front.sv
hdl/rssa_back.sv
hdl/rotated_sorted_array_search.sv
sim/testbench.sv
